>>> design/lbpd_pkg.sv
// ----------------------------------------------------------------------------
// lbpd_pkg
// Shared constants, blink pattern ROM and types for the LED blink pattern
// debouncer.
// ----------------------------------------------------------------------------
package lbpd_pkg;

   localparam int PRESCALE     = 25;
   localparam int DEBOUNCE_MAX = 4;
   localparam int BUTTON_COUNT = 2;
   localparam int NUM_PATTERNS = 6;

   localparam int PRESCALE_W = $clog2(PRESCALE + 1);
   localparam int DBNC_W     = $clog2(DEBOUNCE_MAX + 1);
   localparam int SLOT_W     = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam int PAT_W      = 3;
   localparam int POS_W      = 3;
   localparam int DUR_W      = 4;
   localparam int LEVELS_W   = 2;
   localparam int EVENT_W    = 2;

   localparam logic [PAT_W-1:0] LAST_PATTERN = PAT_W'(NUM_PATTERNS - 1);
   localparam logic [EVENT_W-1:0] EVENT_NONE = '0;

   typedef logic [PAT_W-1:0]    pattern_type;
   typedef logic [POS_W-1:0]    position_type;
   typedef logic [DUR_W-1:0]    duration_type;
   typedef logic [LEVELS_W-1:0] levels_type;
   typedef logic [EVENT_W-1:0]  event_type;

   typedef struct packed {
      logic       step;
      levels_type levels;
   } tick_type;

   function automatic pattern_type pat_clamp(input pattern_type p);
      pat_clamp = (p > LAST_PATTERN) ? LAST_PATTERN : p;
   endfunction

   function automatic position_type pat_len(input pattern_type p);
      case (p)
         3'd4:    pat_len = 3'd4;
         3'd5:    pat_len = 3'd6;
         default: pat_len = 3'd2;
      endcase
   endfunction

   function automatic duration_type pat_entry(input pattern_type p, input position_type pos);
      pat_entry = 4'd0;
      case (p)
         3'd0: pat_entry = (pos == 3'd0) ? 4'd8 : (pos == 3'd1) ? 4'd2 : 4'd0;
         3'd1: pat_entry = (pos < 3'd2) ? 4'd3 : 4'd0;
         3'd2: pat_entry = (pos < 3'd2) ? 4'd1 : 4'd0;
         3'd3: pat_entry = (pos == 3'd0) ? 4'd2 : (pos == 3'd1) ? 4'd8 : 4'd0;
         3'd4: pat_entry = (pos < 3'd3) ? 4'd2 : (pos == 3'd3) ? 4'd8 : 4'd0;
         3'd5: pat_entry = (pos < 3'd5) ? 4'd2 : (pos == 3'd5) ? 4'd8 : 4'd0;
         default: pat_entry = 4'd0;
      endcase
   endfunction

endpackage

>>> design/lbpd_blink.sv
// ----------------------------------------------------------------------------
// lbpd_blink
// Tick prescaler and blink pattern sequencer driving the LED level.
// ----------------------------------------------------------------------------
module lbpd_blink (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  lbpd_pkg::pattern_type pattern_select,
   output logic                 led_next
);
   import lbpd_pkg::*;

   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   position_type          position_ff, position_in;
   duration_type          duration_ff, duration_in;
   pattern_type           active_ff, active_in;
   logic                  led_ff, led_in;

   pattern_type           p;
   position_type          pos;
   position_type          len;
   position_type          pos_inc;
   duration_type          dur_inc;
   logic [PRESCALE_W-1:0] pre_dec;

   always_comb begin
      p           = pat_clamp(active_ff);
      len         = pat_len(p);
      pos         = (position_ff < len) ? position_ff : '0;
      pos_inc     = pos + POS_W'(1);
      dur_inc     = duration_ff + DUR_W'(1);
      pre_dec     = prescale_ff - PRESCALE_W'(1);
      prescale_in = prescale_ff;
      position_in = position_ff;
      duration_in = duration_ff;
      active_in   = active_ff;
      led_in      = led_ff;
      if (step) begin
         prescale_in = pre_dec;
         if (pre_dec == '0) begin
            prescale_in = PRESCALE_W'(PRESCALE);
            duration_in = dur_inc;
            position_in = pos;
            if (dur_inc == pat_entry(p, pos)) begin
               led_in      = ~led_ff;
               duration_in = '0;
               position_in = pos_inc;
               if (pos_inc >= len) begin
                  position_in = '0;
                  active_in   = pat_clamp(pattern_select);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_W'(PRESCALE);
         position_ff <= '0;
         duration_ff <= '0;
         active_ff   <= '0;
         led_ff      <= 1'b1;
      end else begin
         prescale_ff <= prescale_in;
         position_ff <= position_in;
         duration_ff <= duration_in;
         active_ff   <= active_in;
         led_ff      <= led_in;
      end
   end

   assign led_next = led_in;

endmodule

>>> design/lbpd_debounce.sv
// ----------------------------------------------------------------------------
// lbpd_debounce
// Round-robin saturating counter debouncer with press event detection.
// ----------------------------------------------------------------------------
module lbpd_debounce (
   input  logic                clock,
   input  logic                reset,
   input  lbpd_pkg::tick_type  tick,
   output lbpd_pkg::event_type event_next
);
   import lbpd_pkg::*;

   logic [DBNC_W-1:0] count_ff [BUTTON_COUNT];
   logic [DBNC_W-1:0] count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [DBNC_W-1:0] cur;
   logic              pressed;

   always_comb begin
      cur        = count_ff[slot_ff];
      pressed    = (int'(slot_ff) < LEVELS_W) && tick.levels[slot_ff];
      count_in   = cur;
      event_next = EVENT_NONE;
      if (pressed) begin
         if (cur < DBNC_W'(DEBOUNCE_MAX)) begin
            count_in = cur + DBNC_W'(1);
            if (count_in == DBNC_W'(DEBOUNCE_MAX)) begin
               event_next = EVENT_W'(slot_ff) + EVENT_W'(1);
            end
         end
      end else if (cur != '0) begin
         count_in = cur - DBNC_W'(1);
      end
      slot_in = (slot_ff == SLOT_W'(BUTTON_COUNT - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            count_ff[i] <= '0;
         end
         slot_ff <= '0;
      end else if (tick.step) begin
         count_ff[slot_ff] <= count_in;
         slot_ff           <= slot_in;
      end
   end

endmodule

>>> design/led_blink_pattern_debouncer.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_debouncer
// LED blink pattern generator with round-robin button debouncer.
// ----------------------------------------------------------------------------
// Result: an accepted tick loads the result register, which shows it on rsp in the next cycle.
// Throughput: one tick per cycle while rsp is not stalled; the result register accepts a new tick
//   in the same cycle its current result is taken.
// Reset: synchronous, active high; LED on, pattern 0, counters cleared,
//   result register empty, pattern select 0.
module led_blink_pattern_debouncer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [1:0] button_levels
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] led_on, [2:1] press_event
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_data     // [2:0] pattern_select
);
   import lbpd_pkg::*;

   pattern_type select_ff;
   logic        valid_ff, valid_in;
   logic        led_ff;
   event_type   event_ff;
   logic        led_next;
   event_type   event_next;
   tick_type    tick;
   logic        accept;

   assign req_tready  = ~valid_ff | rsp_tready;
   assign accept      = req_tvalid & req_tready;
   assign csr_ready   = 1'b1;
   assign tick        = {accept, req_tdata[LEVELS_W-1:0]};
   assign valid_in    = accept | (valid_ff & ~rsp_tready);

   lbpd_blink u_blink (
      .clock          (clock),
      .reset          (reset),
      .step           (accept),
      .pattern_select (select_ff),
      .led_next       (led_next)
   );

   lbpd_debounce u_debounce (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .event_next (event_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid) begin
            select_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_ff   <= led_next;
         event_ff <= event_next;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, event_ff, led_ff};

endmodule

>>> design/lbpd_checker.sv
// ----------------------------------------------------------------------------
// lbpd_checker
// Port-level checks for the LED blink pattern debouncer.
// ----------------------------------------------------------------------------
module lbpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled transaction changed");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted transaction produced no result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:1] != 2'd3 && rsp_tdata[7:3] == 5'd0)
      else $error("bad result encoding");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind led_blink_pattern_debouncer lbpd_checker u_lbpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> bench/led_blink_pattern_debouncer_checker.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_debouncer_checker
// Watches the tick, result and pattern select channels of the LED blink
// pattern debouncer, runs its own model of the prescaler, blink pattern
// sequencer and round-robin debouncer on every accepted tick, and compares
// each result transaction in order against the predicted LED level and
// press event.
// ----------------------------------------------------------------------------
module led_blink_pattern_debouncer_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [1:0] button_levels
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [0] led_on, [2:1] press_event
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [2:0] csr_data,    // [2:0] pattern_select
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lbpd_pkg::*;

   typedef struct {
      logic      led;
      event_type press;
   } led_result_type;

   led_result_type led_results[$];
   led_result_type got;
   led_result_type want;
   int             result_index;

   pattern_type  select_reg;
   pattern_type  blink_pattern;
   position_type blink_pos;
   duration_type blink_dur;
   logic         led_level;
   int           tick_left;
   int           press_level[BUTTON_COUNT];
   int           scan_slot;

   // {entry count, entries with position 0 in the lowest nibble}
   function automatic logic [26:0] blink_row(input pattern_type p);
      case (p)
         3'd0:    blink_row = {3'd2, 24'h000028};
         3'd1:    blink_row = {3'd2, 24'h000033};
         3'd2:    blink_row = {3'd2, 24'h000011};
         3'd3:    blink_row = {3'd2, 24'h000082};
         3'd4:    blink_row = {3'd4, 24'h008222};
         default: blink_row = {3'd6, 24'h822222};
      endcase
   endfunction

   task automatic advance_tick(input levels_type lv, output led_result_type res);
      pattern_type  p;
      position_type pos;
      position_type len;
      logic [26:0]  row;
      int           s;
      logic         pressed;
      res.press = EVENT_NONE;
      tick_left = tick_left - 1;
      if (tick_left == 0) begin
         p = (blink_pattern > LAST_PATTERN) ? LAST_PATTERN : blink_pattern;
         row = blink_row(p);
         len = row[26:24];
         pos = (blink_pos < len) ? blink_pos : '0;
         tick_left = PRESCALE;
         blink_dur = blink_dur + 1'b1;
         if (blink_dur == row[pos*4 +: 4]) begin
            led_level = ~led_level;
            blink_dur = '0;
            pos = pos + 1'b1;
            if (pos >= len) begin
               pos = '0;
               blink_pattern = (select_reg > LAST_PATTERN) ? LAST_PATTERN : select_reg;
            end
         end
         blink_pos = pos;
      end
      s = (scan_slot < BUTTON_COUNT) ? scan_slot : 0;
      pressed = (s < LEVELS_W) && lv[s];
      if (pressed) begin
         if (press_level[s] < DEBOUNCE_MAX) begin
            press_level[s] = press_level[s] + 1;
            if (press_level[s] == DEBOUNCE_MAX)
               res.press = event_type'(s + 1);
         end
      end else if (press_level[s] > 0) begin
         press_level[s] = press_level[s] - 1;
      end
      s = s + 1;
      scan_slot = (s >= BUTTON_COUNT) ? 0 : s;
      res.led = led_level;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         led_results.delete();
         fail_count = 0;
         result_index = 0;
         select_reg = '0;
         blink_pattern = '0;
         blink_pos = '0;
         blink_dur = '0;
         led_level = 1'b1;
         tick_left = PRESCALE;
         for (int i = 0; i < BUTTON_COUNT; i++)
            press_level[i] = 0;
         scan_slot = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.led = rsp_tdata[0];
            got.press = rsp_tdata[2:1];
            if (led_results.size() == 0) begin
               if (fail_count < 10)
                  $display("result %0d: none expected, got led %0b event %0d",
                           result_index, got.led, got.press);
               fail_count++;
            end else begin
               want = led_results.pop_front();
               if (got.led !== want.led || got.press !== want.press) begin
                  if (fail_count < 10)
                     $display("result %0d: expected led %0b event %0d, got led %0b event %0d",
                              result_index, want.led, want.press, got.led, got.press);
                  fail_count++;
               end
            end
            result_index++;
         end
         if (csr_valid && csr_ready)
            select_reg = csr_data;
         if (req_tvalid && req_tready) begin
            advance_tick(req_tdata[1:0], want);
            led_results.push_back(want);
         end
      end
      pending = led_results.size();
   end

endmodule

>>> bench/led_blink_pattern_debouncer_tb.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_debouncer_tb
// Drives button ticks and pattern select writes into the LED blink pattern
// debouncer with random source gaps and sink stalls, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module led_blink_pattern_debouncer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbpd_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [1:0] button_levels
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] led_on, [2:1] press_event
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_data;    // [2:0] pattern_select
   int         fail_count;
   int         pending;
   logic       quiet;
   int         stall_left;
   int         idle_cycles;

   led_blink_pattern_debouncer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   led_blink_pattern_debouncer_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // stall the result channel in bursts
   always @(negedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_tick(input levels_type lv);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, lv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_run(input levels_type lv, input int n);
      repeat (n) send_tick(lv);
   endtask

   task automatic write_select(input pattern_type sel);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= sel;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly held or bouncing button levels, some pure noise
   task automatic random_ticks(input int n);
      int         sent;
      int         run;
      int         mode;
      int         k;
      levels_type base;
      levels_type lv;
      sent = 0;
      while (sent < n) begin
         mode = $urandom_range(0, 9);
         run  = $urandom_range(1, 12);
         base = levels_type'($urandom_range(0, 3));
         for (k = 0; k < run && sent < n; k++) begin
            if (mode < 6)
               lv = base;
            else if (mode < 8)
               lv = ($urandom_range(0, 3) == 0) ? base ^ levels_type'($urandom_range(1, 3)) : base;
            else
               lv = levels_type'($urandom_range(0, 3));
            send_tick(lv);
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      rsp_tready = 1'b0;
      quiet      = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_run(2'b00, 2);
      send_run(2'b11, 10);
      send_run(2'b00, 3);
      send_run(2'b10, 8);
      send_run(2'b01, 2);

      write_select(3'd2);
      random_ticks(260);
      write_select(3'd7);
      random_ticks(80);
      write_select(3'd6);
      random_ticks(100);
      write_select(3'd3);
      random_ticks(100);
      write_select(3'd4);
      random_ticks(100);
      write_select(3'd1);
      random_ticks(100);
      write_select(3'd5);
      random_ticks(80);
      write_select(3'd0);
      random_ticks(60);
      quiet = 1'b1;
      random_ticks(60);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
design/lbpd_pkg.sv
design/lbpd_blink.sv
design/lbpd_debounce.sv
design/led_blink_pattern_debouncer.sv
design/lbpd_checker.sv
bench/led_blink_pattern_debouncer_checker.sv
bench/led_blink_pattern_debouncer_tb.sv
